[design/teq_pkg.sv]
// Shared types and constants for the touch event qualifier.
package teq_pkg;

    // Configuration register indexes
    localparam logic [2:0] CfgScreenWidth  = 3'd0;
    localparam logic [2:0] CfgScreenHeight = 3'd1;
    localparam logic [2:0] CfgDebounce     = 3'd2;
    localparam logic [2:0] CfgMoveThresh   = 3'd3;
    localparam logic [2:0] CfgMoveInterval = 3'd4;

    // Reset values of the configuration registers
    localparam logic [10:0] RstScreenWidth  = 11'd480;
    localparam logic [10:0] RstScreenHeight = 11'd320;
    localparam logic [15:0] RstDebounce     = 16'd80;
    localparam logic [9:0]  RstMoveThresh   = 10'd2;
    localparam logic [15:0] RstMoveInterval = 16'd20;

    // Event codes
    localparam logic [1:0] EvNone = 2'd0;
    localparam logic [1:0] EvDown = 2'd1;
    localparam logic [1:0] EvMove = 2'd2;
    localparam logic [1:0] EvUp   = 2'd3;

    // Correction: q = (t * M) >> FixShift, M = ceil(k * 2^FixShift / d).
    // Exact while t * d < 2^FixShift, which holds for every segment.
    localparam int unsigned FixShift = 20;
    localparam logic [20:0] MulX1 = 21'((35  * (1 << FixShift) + 29  - 1) / 29);
    localparam logic [20:0] MulX2 = 21'((205 * (1 << FixShift) + 222 - 1) / 222);
    localparam logic [20:0] MulX3 = 21'((205 * (1 << FixShift) + 229 - 1) / 229);
    localparam logic [20:0] MulY1 = 21'(1 << FixShift);
    localparam logic [20:0] MulY2 = 21'((110 * (1 << FixShift) + 112 - 1) / 112);
    localparam logic [20:0] MulY3 = 21'((110 * (1 << FixShift) + 118 - 1) / 118);

    // Corrected point handed from the correction unit to the qualifier
    typedef struct packed {
        logic       ok;
        logic [9:0] x;
        logic [9:0] y;
    } t_corr_pt;

endpackage

[design/teq_corr.sv]
// Mirror, piecewise-linear correction and on-screen check of one sample.
module teq_corr (
    input  logic [10:0]        i_width,
    input  logic [10:0]        i_height,
    input  logic [9:0]         i_sample_x,
    input  logic [9:0]         i_sample_y,
    output teq_pkg::t_corr_pt  o_pt
);

    // One shared constant multiplier per axis; segment picks offset, base and scale
    function automatic logic [10:0] fix_axis(input logic [10:0] v, input logic y_axis);
        logic [10:0] t;
        logic [10:0] base;
        logic [20:0] m;
        logic [31:0] prod;
        logic [31:0] q;
        if (!y_axis) begin
            if (v <= 11'd29) begin
                t = v;            base = 11'd0;   m = teq_pkg::MulX1;
            end else if (v <= 11'd251) begin
                t = v - 11'd29;   base = 11'd35;  m = teq_pkg::MulX2;
            end else begin
                t = v - 11'd251;  base = 11'd240; m = teq_pkg::MulX3;
            end
        end else begin
            if (v <= 11'd70) begin
                t = v;            base = 11'd0;   m = teq_pkg::MulY1;
            end else if (v <= 11'd182) begin
                t = v - 11'd70;   base = 11'd70;  m = teq_pkg::MulY2;
            end else begin
                t = v - 11'd182;  base = 11'd180; m = teq_pkg::MulY3;
            end
        end
        prod = {21'd0, t} * {11'd0, m};
        q    = prod >> teq_pkg::FixShift;
        return base + q[10:0];
    endfunction

    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic [10:0]        fx;
    logic [10:0]        fy;

    // Mirrored value spans -1024..2046; negative always corrects below zero
    assign mx = $signed({2'b00, i_width})  - 13'sd1 - $signed({3'b000, i_sample_x});
    assign my = $signed({2'b00, i_height}) - 13'sd1 - $signed({3'b000, i_sample_y});

    assign fx = fix_axis(mx[10:0], 1'b0);
    assign fy = fix_axis(my[10:0], 1'b1);

    assign o_pt.ok = !mx[12] && !my[12] && (fx < i_width) && (fy < i_height)
                     && !fx[10] && !fy[10];
    assign o_pt.x  = fx[9:0];
    assign o_pt.y  = fy[9:0];

endmodule

[design/touch_event_qualifier_core.sv]
// Top level of the touch event qualifier: sample register, qualifier state, event register.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one touch sample per beat: pressed flag,
//   raw x and y, and a millisecond timestamp. Output channel (o_valid / i_ready) carries
//   exactly one event beat per sample: kind (none, down, move, up) and the point.
//   A sample that is accepted is captured in the sample register, corrected and
//   qualified there, and its event is then captured in the event register and shown
//   from it. Throughput is one sample per cycle while the receiver does not stall; the
//   rate is set by the single qualifier state update, which happens as the sample moves
//   to the event register, so the next sample always sees the updated state.
//   When the receiver stalls, the event register holds its beat and the sample register
//   keeps one more sample; o_ready drops once both are full and comes back in the same
//   cycle that i_ready frees the event register.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user must
//   write it only while no sample is in flight, as the block does not enforce this.
//   Synchronous active-low reset loads the default screen size, threshold and timing values,
//   clears the held flag, timestamps and last point, and empties both registers.
module touch_event_qualifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // sample channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_touch_pressed,
    input  logic [9:0]  i_sample_x,
    input  logic [9:0]  i_sample_y,
    input  logic [31:0] i_time_ms,
    // event channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_kind,
    output logic [9:0]  o_point_x,
    output logic [9:0]  o_point_y
);

    // configuration registers
    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [15:0] r_debounce;
    logic [9:0]  r_move_thr;
    logic [15:0] r_move_ivl;

    // sample register
    logic        r_s1_vld;
    logic        r_s1_pressed;
    logic [9:0]  r_s1_x;
    logic [9:0]  r_s1_y;
    logic [31:0] r_s1_time;

    // qualifier state
    logic        r_held;
    logic [31:0] r_press_time;
    logic [31:0] r_move_time;
    logic [9:0]  r_last_x;
    logic [9:0]  r_last_y;

    // event register
    logic        r_out_vld;
    logic [1:0]  r_kind;
    logic [9:0]  r_px;
    logic [9:0]  r_py;

    logic        adv;
    teq_pkg::t_corr_pt corr;

    logic        pressed;
    logic [31:0] press_gap;
    logic [31:0] move_gap;
    logic [9:0]  dx;
    logic [9:0]  dy;

    logic        n_held;
    logic [31:0] n_press_time;
    logic [31:0] n_move_time;
    logic [9:0]  n_last_x;
    logic [9:0]  n_last_y;
    logic [1:0]  n_kind;
    logic [9:0]  n_px;
    logic [9:0]  n_py;

    // sample leaves the sample register when the event register is free or drains
    assign adv     = r_s1_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_s1_vld || adv;

    assign o_valid      = r_out_vld;
    assign o_event_kind = r_kind;
    assign o_point_x    = r_px;
    assign o_point_y    = r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= teq_pkg::RstScreenWidth;
            r_height   <= teq_pkg::RstScreenHeight;
            r_debounce <= teq_pkg::RstDebounce;
            r_move_thr <= teq_pkg::RstMoveThresh;
            r_move_ivl <= teq_pkg::RstMoveInterval;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                teq_pkg::CfgScreenWidth:  r_width    <= i_cfg_data[10:0];
                teq_pkg::CfgScreenHeight: r_height   <= i_cfg_data[10:0];
                teq_pkg::CfgDebounce:     r_debounce <= i_cfg_data;
                teq_pkg::CfgMoveThresh:   r_move_thr <= i_cfg_data[9:0];
                teq_pkg::CfgMoveInterval: r_move_ivl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample register; payload unreset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_ready) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_pressed <= i_touch_pressed;
            r_s1_x       <= i_sample_x;
            r_s1_y       <= i_sample_y;
            r_s1_time    <= i_time_ms;
        end
    end

    teq_corr u_corr (
        .i_width    (r_width),
        .i_height   (r_height),
        .i_sample_x (r_s1_x),
        .i_sample_y (r_s1_y),
        .o_pt       (corr)
    );

    // off-screen corrected point counts as a release
    assign pressed   = r_s1_pressed && corr.ok;
    assign press_gap = r_s1_time - r_press_time;
    assign move_gap  = r_s1_time - r_move_time;
    assign dx        = (corr.x > r_last_x) ? corr.x - r_last_x : r_last_x - corr.x;
    assign dy        = (corr.y > r_last_y) ? corr.y - r_last_y : r_last_y - corr.y;

    always_comb begin
        n_held       = r_held;
        n_press_time = r_press_time;
        n_move_time  = r_move_time;
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;
        n_kind       = teq_pkg::EvNone;
        n_px         = 10'd0;
        n_py         = 10'd0;
        if (!pressed) begin
            if (r_held) begin
                n_held = 1'b0;
                n_kind = teq_pkg::EvUp;
                n_px   = r_last_x;
                n_py   = r_last_y;
            end
        end else if (!r_held) begin
            // debounce: gap strictly longer than the window
            if (press_gap > {16'd0, r_debounce}) begin
                n_held       = 1'b1;
                n_press_time = r_s1_time;
                n_move_time  = r_s1_time;
                n_last_x     = corr.x;
                n_last_y     = corr.y;
                n_kind       = teq_pkg::EvDown;
                n_px         = corr.x;
                n_py         = corr.y;
            end
        end else begin
            if ((dx >= r_move_thr || dy >= r_move_thr) && move_gap >= {16'd0, r_move_ivl}) begin
                n_last_x    = corr.x;
                n_last_y    = corr.y;
                n_move_time = r_s1_time;
                n_kind      = teq_pkg::EvMove;
                n_px        = corr.x;
                n_py        = corr.y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 1'b0;
            r_press_time <= 32'd0;
            r_move_time  <= 32'd0;
            r_last_x     <= 10'd0;
            r_last_y     <= 10'd0;
        end else if (adv) begin
            r_held       <= n_held;
            r_press_time <= n_press_time;
            r_move_time  <= n_move_time;
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
        end
    end

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kind <= n_kind;
            r_px   <= n_px;
            r_py   <= n_py;
        end
    end

`ifndef SYNTHESIS
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_kind == teq_pkg::EvNone) |-> (r_px == 10'd0 && r_py == 10'd0))
        else $error("none event with nonzero point");

    a_down_sets_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_kind == teq_pkg::EvDown) |=> (r_held && r_press_time == r_move_time))
        else $error("down did not set held state");

    a_up_from_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_kind == teq_pkg::EvUp) |-> (r_held && !pressed))
        else $error("up without a hold");

    a_move_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_kind == teq_pkg::EvMove) |-> (r_held && pressed))
        else $error("move while not held");

    a_sample_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !adv) |=> r_s1_vld)
        else $error("stalled sample dropped");
`endif

endmodule

[verif/tb_top.sv]
// Testbench for touch_event_qualifier_core: gesture traffic checked against a local event model.
`timescale 1ns / 1ps

module tb_top;
    import teq_pkg::*;

    // A beat moves after each side's idle gap, drawn up to MaxWait, and the pass through the
    // sample and event registers, so reaching QuietLimit without any beat means the block is stuck.
    localparam int unsigned QuietLimit = 1000;
    localparam int unsigned MaxWait    = 18;

    // One event beat as the block reports it
    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] x;
        logic [9:0] y;
    } t_evt_beat;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_touch_pressed;
    logic [9:0]  i_sample_x;
    logic [9:0]  i_sample_y;
    logic [31:0] i_time_ms;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_event_kind;
    logic [9:0]  o_point_x;
    logic [9:0]  o_point_y;

    touch_event_qualifier_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_touch_pressed (i_touch_pressed),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .i_time_ms       (i_time_ms),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_kind    (o_event_kind),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y)
    );

    // 2 ns period
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Event model: register copies and qualifier state, as after reset
    // ------------------------------------------------------------------
    logic [10:0] cfg_width    = RstScreenWidth;
    logic [10:0] cfg_height   = RstScreenHeight;
    logic [15:0] cfg_debounce = RstDebounce;
    logic [9:0]  cfg_thresh   = RstMoveThresh;
    logic [15:0] cfg_interval = RstMoveInterval;

    logic        held     = 1'b0;
    logic [31:0] press_ms = '0;
    logic [31:0] move_ms  = '0;
    logic [9:0]  last_x   = '0;
    logic [9:0]  last_y   = '0;

    // Events predicted for accepted samples, oldest first
    t_evt_beat pending_events[$];

    // Run bookkeeping
    int          n_samples  = 0;
    int          n_settings = 0;
    int          n_errors   = 0;
    int          kind_count[4] = '{0, 0, 0, 0};
    int unsigned quiet_cycles = 0;

    // Idle switches for sample source and event sink, redrawn now and then
    logic        send_idle = 1'b1;
    logic        recv_idle = 1'b1;

    // Sample time base for random traffic
    logic [31:0] now_ms = '0;

    // ------------------------------------------------------------------
    // Correction curves: three segments per axis, division toward zero
    // ------------------------------------------------------------------
    function automatic int correct_x(input int v);
        if (v <= 29) begin
            return (v * 35) / 29;
        end else if (v <= 251) begin
            return 35 + ((v - 29) * 205) / 222;
        end else begin
            return 240 + ((v - 251) * 205) / 229;
        end
    endfunction

    function automatic int correct_y(input int v);
        if (v <= 70) begin
            return v;
        end else if (v <= 182) begin
            return 70 + ((v - 70) * 110) / 112;
        end else begin
            return 180 + ((v - 182) * 110) / 118;
        end
    endfunction

    // Qualify one sample: mirror, correct, range check, then down/move/up decision.
    // Updates the model state the same way the block does.
    function automatic t_evt_beat qualify_sample(input logic pressed, input logic [9:0] sx,
                                                 input logic [9:0] sy, input logic [31:0] t_ms);
        int          w;
        int          h;
        int          cx;
        int          cy;
        int          dx;
        int          dy;
        int          thr;
        logic        on_screen;
        logic [31:0] since;
        t_evt_beat   beat;
        beat      = '{EvNone, 10'd0, 10'd0};
        w         = int'(cfg_width);
        h         = int'(cfg_height);
        thr       = int'(cfg_thresh);
        cx        = 0;
        cy        = 0;
        on_screen = pressed;
        if (pressed) begin
            cx = correct_x(w - 1 - int'(sx));
            cy = correct_y(h - 1 - int'(sy));
            // off-screen points (incl. zero-size screen) count as released
            if (cx < 0 || cx >= w || cx > 1023 || cy < 0 || cy >= h || cy > 1023) begin
                on_screen = 1'b0;
            end
        end
        if (!on_screen) begin
            // release after a hold reports the last point; otherwise nothing
            if (held) begin
                held = 1'b0;
                beat = '{EvUp, last_x, last_y};
            end
        end else if (!held) begin
            // press inside the debounce window is dropped with no state change
            since = t_ms - press_ms;
            if (since > 32'(cfg_debounce)) begin
                held     = 1'b1;
                press_ms = t_ms;
                move_ms  = t_ms;
                last_x   = 10'(cx);
                last_y   = 10'(cy);
                beat     = '{EvDown, last_x, last_y};
            end
        end else begin
            dx    = (cx > int'(last_x)) ? cx - int'(last_x) : int'(last_x) - cx;
            dy    = (cy > int'(last_y)) ? cy - int'(last_y) : int'(last_y) - cy;
            since = t_ms - move_ms;
            if ((dx >= thr || dy >= thr) && since >= 32'(cfg_interval)) begin
                last_x  = 10'(cx);
                last_y  = 10'(cy);
                move_ms = t_ms;
                beat    = '{EvMove, last_x, last_y};
            end
        end
        return beat;
    endfunction

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    // ------------------------------------------------------------------
    // Sample source: idle gap, raise valid with payload, hold until accepted.
    // Valid stays high across back-to-back beats (gap of zero).
    // ------------------------------------------------------------------
    task automatic send_sample(input logic pressed, input int sx, input int sy,
                               input logic [31:0] t_ms);
        int        gap;
        t_evt_beat want;
        gap = send_idle ? $urandom_range(0, MaxWait) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_touch_pressed <= pressed;
        i_sample_x      <= 10'(sx);
        i_sample_y      <= 10'(sy);
        i_time_ms       <= t_ms;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = qualify_sample(pressed, 10'(sx), 10'(sy), t_ms);
        pending_events.push_back(want);
        kind_count[want.kind]++;
        n_samples++;
    endtask

    // Compare one accepted event beat with the oldest prediction
    task automatic check_event_beat();
        t_evt_beat want;
        if (pending_events.size() == 0) begin
            $display("%0t: event beat kind %0d (%0d,%0d) with no sample pending",
                     $time, o_event_kind, o_point_x, o_point_y);
            n_errors++;
        end else begin
            want = pending_events.pop_front();
            if (o_event_kind !== want.kind) begin
                $display("%0t: event kind expected %0d, got %0d", $time, want.kind, o_event_kind);
                n_errors++;
            end
            if (o_point_x !== want.x) begin
                $display("%0t: point x expected %0d, got %0d", $time, want.x, o_point_x);
                n_errors++;
            end
            if (o_point_y !== want.y) begin
                $display("%0t: point y expected %0d, got %0d", $time, want.y, o_point_y);
                n_errors++;
            end
        end
    endtask

    // Event sink: random stall per beat, then ready held until a beat is taken
    initial begin : event_sink
        int stall;
        i_ready = 1'b0;
        forever begin
            stall = recv_idle ? $urandom_range(0, MaxWait) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            check_event_beat();
        end
    end

    // Watchdog: any beat on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit) begin
                $display("%0t: no beat for %0d cycles, %0d events outstanding",
                         $time, quiet_cycles, pending_events.size());
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Drop valid and wait until every predicted event has come back
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgScreenWidth:  cfg_width    = data[10:0];
            CfgScreenHeight: cfg_height   = data[10:0];
            CfgDebounce:     cfg_debounce = data;
            CfgMoveThresh:   cfg_thresh   = data[9:0];
            CfgMoveInterval: cfg_interval = data;
            default: ;
        endcase
    endtask

    // Full register set; unused upper data bits carry junk the block must ignore
    task automatic apply_settings(input logic [10:0] w, input logic [10:0] h,
                                  input logic [15:0] deb, input logic [9:0] thr,
                                  input logic [15:0] ival);
        settle();
        write_cfg(CfgScreenWidth,  {5'($urandom), w});
        write_cfg(CfgScreenHeight, {5'($urandom), h});
        write_cfg(CfgDebounce,     deb);
        write_cfg(CfgMoveThresh,   {6'($urandom), thr});
        write_cfg(CfgMoveInterval, ival);
        n_settings++;
    endtask

    task automatic draw_idle();
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
    endtask

    // Unstructured sample, occasionally with a jump anywhere in the time range
    task automatic send_noise();
        if ($urandom_range(0, 19) == 0) begin
            now_ms = $urandom;
        end else begin
            now_ms += $urandom_range(0, 100);
        end
        send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), now_ms);
    endtask

    // Well-formed gesture: press after a debounce-scaled gap, a drag of jittered
    // points paced around the move interval, then a release.
    task automatic run_gesture();
        int xmax;
        int ymax;
        int px;
        int py;
        int reach;
        int moves;
        xmax  = (cfg_width == 0 || cfg_width > 1024) ? 1023 : int'(cfg_width) - 1;
        ymax  = (cfg_height == 0 || cfg_height > 1024) ? 1023 : int'(cfg_height) - 1;
        reach = 3 * int'(cfg_thresh) + 3;
        now_ms += $urandom_range(0, 2 * int'(cfg_debounce) + 40);
        px = $urandom_range(0, xmax);
        py = $urandom_range(0, ymax);
        send_sample(1'b1, px, py, now_ms);
        moves = $urandom_range(0, 12);
        repeat (moves) begin
            now_ms += $urandom_range(0, 2 * int'(cfg_interval) + 4);
            px = clamp_coord(px + int'($urandom_range(0, 2 * reach)) - reach);
            py = clamp_coord(py + int'($urandom_range(0, 2 * reach)) - reach);
            send_sample(1'b1, px, py, now_ms);
        end
        now_ms += $urandom_range(1, 30);
        send_sample(1'b0, $urandom_range(0, 1023), $urandom_range(0, 1023), now_ms);
    endtask

    // Mostly gestures, a quarter noise; idle pattern redrawn at random
    task automatic run_traffic(input int n_items);
        int stop_at;
        stop_at = n_samples + n_items;
        while (n_samples < stop_at) begin
            if ($urandom_range(0, 7) == 0) begin
                draw_idle();
            end
            if ($urandom_range(0, 3) == 0) begin
                send_noise();
            end else begin
                run_gesture();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings (480x320, debounce 80, threshold 2, interval 20).
    // Mirrored point is (479-x, 319-y).
    task automatic test_directed_gestures();
        send_sample(1'b0, 1023, 1023, 32'd5);           // release while idle
        send_sample(1'b1, 0, 0, 32'd50);                 // press inside debounce
        send_sample(1'b1, 0, 0, 32'd81);                 // down, far corner
        send_sample(1'b1, 0, 0, 32'd200);                // held, no change
        send_sample(1'b1, 10, 0, 32'd205);               // move
        send_sample(1'b1, 20, 0, 32'd210);               // too soon for a move
        send_sample(1'b1, 21, 0, 32'd225);               // move
        send_sample(1'b1, 1023, 0, 32'd230);             // mirrored x negative -> up
        send_sample(1'b1, 479, 319, 32'd240);            // down at origin
        send_sample(1'b1, 478, 318, 32'd260);            // one pixel, below the threshold: no move
        send_sample(1'b0, 478, 318, 32'd261);            // up
        send_sample(1'b0, 0, 0, 32'd262);                // release while idle
        send_sample(1'b1, 250, 160, 32'hFFFF_FFF0);      // down near time wrap
        send_sample(1'b1, 100, 100, 32'h0000_0004);      // move across the wrap
        send_sample(1'b1, 0, 1023, 32'd10);              // y off screen -> up
        send_sample(1'b1, 450, 249, 32'h50);             // down on segment ends
        send_sample(1'b1, 449, 248, 32'h64);             // first point of middle segments
        send_sample(1'b1, 228, 137, 32'h8C);             // last point of middle segments
        send_sample(1'b1, 227, 136, 32'hB4);             // first point of top segments
        send_sample(1'b1, 479, 0, 32'hC0);               // big jump, interval met: move
        send_sample(1'b0, 0, 0, 32'hC8);                 // up
    endtask

    // Corner settings: zero, unit and oversize screens, timing registers at both ends
    task automatic test_config_extremes();
        apply_settings(11'd0, 11'd0, 16'd80, 10'd2, 16'd20);
        run_traffic(60);
        apply_settings(11'd1, 11'd1, 16'd0, 10'd0, 16'd0);
        run_traffic(80);
        apply_settings(11'd2047, 11'd2047, 16'd0, 10'd0, 16'd0);
        run_traffic(80);
        apply_settings(11'd1024, 11'd1024, 16'hFFFF, 10'd1023, 16'hFFFF);
        run_traffic(80);
        apply_settings(11'd1024, 11'd1, 16'd0, 10'd0, 16'hFFFF);
        run_traffic(60);
        apply_settings(11'd1, 11'd1024, 16'd5, 10'd1023, 16'd0);
        run_traffic(60);
    endtask

    // Typical panels with random geometry and timing; sometimes oversize
    task automatic test_random_configs();
        logic [10:0] w;
        logic [10:0] h;
        repeat (6) begin
            w = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1025, 2047))
                                            : 11'($urandom_range(1, 1024));
            h = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(1025, 2047))
                                            : 11'($urandom_range(1, 1024));
            apply_settings(w, h, 16'($urandom_range(0, 200)), 10'($urandom_range(0, 15)),
                           16'($urandom_range(0, 60)));
            draw_idle();
            run_traffic(100);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CfgScreenWidth;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_touch_pressed = 1'b0;
        i_sample_x      = '0;
        i_sample_y      = '0;
        i_time_ms       = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_gestures();
        test_config_extremes();
        test_random_configs();
        settle();

        $display("covered %0d samples over %0d register settings plus reset values",
                 n_samples, n_settings);
        $display("events seen: none %0d, down %0d, move %0d, up %0d; mismatches %0d",
                 kind_count[EvNone], kind_count[EvDown], kind_count[EvMove],
                 kind_count[EvUp], n_errors);
        if (n_errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
